// ===== rtl/core/lkvc_pkg.sv =====
// Shared constants and types for the LRU key-value cache.
package lkvc_pkg;

    localparam int ENTRIES = 4;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int DATA_W  = 32;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [DATA_W-1:0] data_t;

    typedef enum logic
    {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } cmd_t;

    typedef enum logic [2:0]
    {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_WRITE = 3'b100
    } state_t;

    typedef struct packed
    {
        logic  hit;
        idx_t  hit_idx;
        logic  has_free;
        idx_t  free_idx;
        logic  has_min;
        data_t min_stamp;
        idx_t  min_idx;
    } scan_t;

endpackage

// ===== rtl/core/lkvc_scan.sv =====
// Shared match and age-compare unit, walked over one entry per cycle while step is high.
module lkvc_scan
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          clear,
    input  logic          step,
    input  lkvc_pkg::idx_t idx,
    input  logic          entry_valid,
    input  lkvc_pkg::data_t entry_key,
    input  lkvc_pkg::data_t entry_stamp,
    input  lkvc_pkg::data_t key,
    output lkvc_pkg::scan_t result
);
    import lkvc_pkg::*;

    scan_t scan_reg;
    scan_t scan_next;

    always_comb
    begin
        scan_next = scan_reg;
        if (clear)
        begin
            scan_next = '0;
        end
        else if (step)
        begin
            if (entry_valid && (entry_key == key) && !scan_reg.hit)
            begin
                scan_next.hit     = 1'b1;
                scan_next.hit_idx = idx;
            end
            if (!entry_valid && !scan_reg.has_free)
            begin
                scan_next.has_free = 1'b1;
                scan_next.free_idx = idx;
            end
            if (entry_valid && (!scan_reg.has_min || (entry_stamp < scan_reg.min_stamp)))
            begin
                scan_next.has_min   = 1'b1;
                scan_next.min_stamp = entry_stamp;
                scan_next.min_idx   = idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
        end
    end

    assign result = scan_reg;

endmodule

// ===== rtl/core/lru_key_value_cache_unit.sv =====
// Top level of the fully associative LRU key-value cache.
// Usage:
//   Command channel: a word (command, key, write_value) is taken at a rising
//   edge with start high and busy low. command 0 is a get, 1 is a put.
//   Result channel: every get returns one word (found, read_value), shown for
//   exactly one cycle with done high; a put returns nothing. read_value is
//   zero on a miss. The receiver cannot stall; each word must be taken in
//   the cycle that done is high.
//   Timing: each word walks every entry in the scan state, one entry per cycle
//   through the shared match/age compare unit, and then passes through the
//   write-back state. busy is high through both, and done rises on the edge
//   that ends the write-back. A new word may be started in the cycle done is
//   high. The block takes a new word only while idle, once the entry walk and
//   the write-back of the last word are through.
//   Reset: all entries invalid, use clock zero, block idle. Entry key,
//   value and stamp storage is not cleared; it is only read when valid.
module lru_key_value_cache_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                command,
    input  logic signed [31:0]  key,
    input  logic signed [31:0]  write_value,
    output logic                done,
    output logic                found,
    output logic signed [31:0]  read_value
);
    import lkvc_pkg::*;

    localparam idx_t LAST_IDX = idx_t'(ENTRIES - 1);

    state_t state_reg, state_next;
    idx_t   idx_reg, idx_next;
    logic   cmd_reg;
    data_t  key_reg;
    data_t  wval_reg;
    data_t  clock_reg;

    data_t  entry_key_reg   [ENTRIES];
    data_t  entry_value_reg [ENTRIES];
    data_t  entry_stamp_reg [ENTRIES];
    logic   [ENTRIES-1:0] entry_valid_reg;

    logic   done_reg;
    logic   found_reg;
    data_t  read_value_reg;

    logic   accept;
    scan_t  scan;
    idx_t   victim;

    assign accept = start && (state_reg == ST_IDLE);

    lkvc_scan u_scan
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (accept),
        .step        (state_reg == ST_SCAN),
        .idx         (idx_reg),
        .entry_valid (entry_valid_reg[idx_reg]),
        .entry_key   (entry_key_reg[idx_reg]),
        .entry_stamp (entry_stamp_reg[idx_reg]),
        .key         (key_reg),
        .result      (scan)
    );

    always_comb
    begin
        if (scan.hit)
        begin
            victim = scan.hit_idx;
        end
        else if (scan.has_free)
        begin
            victim = scan.free_idx;
        end
        else
        begin
            victim = scan.min_idx;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                    idx_next   = '0;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    idx_next = idx_reg + idx_t'(1);
                end
            end
            ST_WRITE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            clock_reg       <= '0;
            entry_valid_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            done_reg  <= (state_reg == ST_WRITE) && (cmd_reg == CMD_GET);
            if (state_reg == ST_WRITE)
            begin
                if (cmd_reg == CMD_GET)
                begin
                    if (scan.hit)
                    begin
                        clock_reg <= clock_reg + 32'd1;
                    end
                end
                else
                begin
                    entry_valid_reg[victim] <= 1'b1;
                    clock_reg               <= clock_reg + 32'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            key_reg  <= data_t'(key);
            wval_reg <= data_t'(write_value);
        end
        if (state_reg == ST_WRITE)
        begin
            if (cmd_reg == CMD_GET)
            begin
                found_reg      <= scan.hit;
                read_value_reg <= scan.hit ? entry_value_reg[scan.hit_idx] : '0;
                if (scan.hit)
                begin
                    entry_stamp_reg[scan.hit_idx] <= clock_reg;
                end
            end
            else
            begin
                entry_key_reg[victim]   <= key_reg;
                entry_value_reg[victim] <= wval_reg;
                entry_stamp_reg[victim] <= clock_reg;
            end
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign found      = found_reg;
    assign read_value = signed'(read_value_reg);

endmodule

// ===== rtl/core/lkvc_checker.sv =====
// Port-level checker for the LRU key-value cache, bound to the top level.
module lkvc_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               command,
    input logic               done,
    input logic               found,
    input logic signed [31:0] read_value
);
    import lkvc_pkg::*;

    localparam int LAT = ENTRIES + 2;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while busy");

    a_get_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_GET) |-> ##LAT done)
        else $error("get did not return a word on time");

    a_put_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && command == CMD_PUT) |-> ##LAT !done)
        else $error("put returned a word");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (read_value == 32'sd0))
        else $error("miss with nonzero read_value");

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .done       (done),
    .found      (found),
    .read_value (read_value)
);

// ===== bench/tb_lru_key_value_cache_unit.sv =====
// Self-checking testbench for the LRU key-value cache: directed and random get/put traffic.
module tb_lru_key_value_cache_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import lkvc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_WORDS = 2000;
    localparam int POOL_SIZE = 6;

    typedef struct
    {
        logic        found;
        logic [31:0] value;
    } lookup_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               command;
    logic signed [31:0] key;
    logic signed [31:0] write_value;
    logic               done;
    logic               found;
    logic signed [31:0] read_value;

    // cache contents as the bench expects them
    logic [31:0] cache_key   [ENTRIES];
    logic [31:0] cache_value [ENTRIES];
    logic [31:0] cache_stamp [ENTRIES];
    logic        cache_valid [ENTRIES];
    logic [31:0] cache_clock;

    lookup_t     pending_lookups[$];
    lookup_t     expected_word;
    logic [31:0] key_pool[POOL_SIZE];
    bit          no_idle;
    int          mismatches;
    int          cycles;
    int          gets_sent;
    int          get_hits;
    int          puts_sent;
    int          evictions;
    int          words_checked;

    lru_key_value_cache_unit dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .key         (key),
        .write_value (write_value),
        .done        (done),
        .found       (found),
        .read_value  (read_value)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_lookups.size() == 0)
            begin
                $error("result word with no lookup pending: found=%0b read_value=%h",
                       found, read_value);
                mismatches++;
            end
            else
            begin
                expected_word = pending_lookups.pop_front();
                words_checked++;
                if (found !== expected_word.found)
                begin
                    $error("found: expected %0b, got %0b", expected_word.found, found);
                    mismatches++;
                end
                if (read_value !== expected_word.value)
                begin
                    $error("read_value: expected %h, got %h", expected_word.value, read_value);
                    mismatches++;
                end
            end
        end
    end

    task automatic predict_word(input cmd_t cmd, input logic [31:0] k, input logic [31:0] v);
        int      hit_idx;
        int      victim;
        lookup_t res;
        hit_idx = -1;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit_idx < 0 && cache_valid[i] && cache_key[i] == k)
                hit_idx = i;
        end
        if (cmd == CMD_GET)
        begin
            res.found = (hit_idx >= 0);
            res.value = '0;
            if (hit_idx >= 0)
            begin
                res.value = cache_value[hit_idx];
                cache_stamp[hit_idx] = cache_clock;
                cache_clock = cache_clock + 32'd1;
                get_hits++;
            end
            pending_lookups.push_back(res);
            gets_sent++;
        end
        else
        begin
            victim = hit_idx;
            if (victim < 0)
            begin
                for (int i = ENTRIES - 1; i >= 0; i--)
                begin
                    if (!cache_valid[i])
                        victim = i;
                end
                if (victim < 0)
                begin
                    victim = 0;
                    for (int i = 1; i < ENTRIES; i++)
                    begin
                        if (cache_stamp[i] < cache_stamp[victim])
                            victim = i;
                    end
                    evictions++;
                end
                cache_key[victim] = k;
                cache_valid[victim] = 1'b1;
            end
            cache_value[victim] = v;
            cache_stamp[victim] = cache_clock;
            cache_clock = cache_clock + 32'd1;
            puts_sent++;
        end
    endtask

    // called just after a rising edge; returns just after the accepting edge
    task automatic send_word(input cmd_t cmd, input logic [31:0] k, input logic [31:0] v);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(99) < 7)
            gap = $urandom_range(1, 8);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        command     <= cmd;
        key         <= k;
        write_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_word(cmd, k, v);
    endtask

    task automatic test_reset_misses();
        send_word(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_word(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_word(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_fill_and_read();
        send_word(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_word(CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_word(CMD_GET, 32'h8000_0000, 32'h0000_0000);
        send_word(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        send_word(CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_update_in_place();
        send_word(CMD_PUT, 32'h0000_0000, 32'h5A5A_5A5A);
        send_word(CMD_GET, 32'h0000_0000, 32'h0000_0000);
    endtask

    // oldest entry goes first; a refreshed entry survives
    task automatic test_lru_eviction();
        send_word(CMD_GET, 32'h8000_0000, 32'h0000_0000);
        send_word(CMD_PUT, 32'h0000_1234, 32'hA5A5_A5A5);
        send_word(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        send_word(CMD_GET, 32'h0000_1234, 32'h0000_0000);
        send_word(CMD_PUT, 32'h7FFF_FFFF, 32'h0000_0001);
        send_word(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    endtask

    // small key pool keeps hits and evictions frequent
    task automatic test_random_traffic();
        cmd_t        cmd;
        logic [31:0] k;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        key_pool[4] = $urandom;
        key_pool[5] = $urandom;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            no_idle = (n >= 800 && n < 1100);
            if (n % 250 == 249)
            begin
                for (int j = 0; j < POOL_SIZE; j++)
                    key_pool[j] = $urandom;
            end
            cmd = $urandom_range(1) ? CMD_PUT : CMD_GET;
            if ($urandom_range(99) < 15)
                k = $urandom;
            else
                k = key_pool[$urandom_range(POOL_SIZE - 1)];
            send_word(cmd, k, $urandom);
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        start       <= 1'b0;
        command     <= 1'b0;
        key         <= '0;
        write_value <= '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            cache_key[i]   = '0;
            cache_value[i] = '0;
            cache_stamp[i] = '0;
            cache_valid[i] = 1'b0;
        end
        cache_clock = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_misses();
        test_fill_and_read();
        test_update_in_place();
        test_lru_eviction();
        test_random_traffic();

        start <= 1'b0;
        while (pending_lookups.size() != 0)
            @(posedge clk);
        repeat (2 * (ENTRIES + 1)) @(posedge clk);

        $display("Ran %0d gets (%0d hits) and %0d puts (%0d replacing a valid entry)",
                 gets_sent, get_hits, puts_sent, evictions);
        $display("Checked %0d result words, %0d field mismatches", words_checked, mismatches);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
